// ----- rtl/lels_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lels_pkg
// Shared constants, codes, types and three-valued helpers for the levelised
// event-driven gate simulator.
// ----------------------------------------------------------------------------
package lels_pkg;

   localparam int NET_COUNT_DEF         = 1024;
   localparam int MAX_FANIN_DEF         = 8;
   localparam int MAX_FANOUT_DEF        = 8;
   localparam int LEVEL_COUNT_DEF       = 64;
   localparam int LEVEL_QUEUE_DEPTH_DEF = 128;
   localparam int FF_COUNT_DEF          = 256;

   localparam logic [2:0] MODE_GATE     = 3'd0;
   localparam logic [2:0] MODE_FANIN    = 3'd1;
   localparam logic [2:0] MODE_FANOUT   = 3'd2;
   localparam logic [2:0] MODE_APPLY    = 3'd3;
   localparam logic [2:0] MODE_RUN      = 3'd4;
   localparam logic [2:0] MODE_READ_NET = 3'd5;
   localparam logic [2:0] MODE_READ_FF  = 3'd6;
   localparam logic [2:0] MODE_NONE     = 3'd7;

   localparam logic [1:0] VAL_ZERO = 2'd0;
   localparam logic [1:0] VAL_ONE  = 2'd1;
   localparam logic [1:0] VAL_X    = 2'd2;

   localparam logic [3:0] KIND_AND     = 4'd0;
   localparam logic [3:0] KIND_NAND    = 4'd1;
   localparam logic [3:0] KIND_OR      = 4'd2;
   localparam logic [3:0] KIND_NOR     = 4'd3;
   localparam logic [3:0] KIND_NOT     = 4'd4;
   localparam logic [3:0] KIND_BUF     = 4'd5;
   localparam logic [3:0] KIND_DFF     = 4'd6;
   localparam logic [3:0] KIND_XOR     = 4'd7;
   localparam logic [3:0] KIND_XNOR    = 4'd8;
   localparam logic [3:0] KIND_OUTPUT  = 4'd9;
   localparam logic [3:0] KIND_MYSTERY = 4'd15;

   typedef struct packed {
      logic       clear;
      logic       step;
      logic [3:0] kind;
   } fold_ctl_type;

   function automatic logic [1:0] t_and(input logic [1:0] a, input logic [1:0] b);
      if (a == VAL_ZERO || b == VAL_ZERO) return VAL_ZERO;
      if (a == VAL_ONE && b == VAL_ONE) return VAL_ONE;
      return VAL_X;
   endfunction

   function automatic logic [1:0] t_or(input logic [1:0] a, input logic [1:0] b);
      if (a == VAL_ONE || b == VAL_ONE) return VAL_ONE;
      if (a == VAL_ZERO && b == VAL_ZERO) return VAL_ZERO;
      return VAL_X;
   endfunction

   function automatic logic [1:0] t_not(input logic [1:0] a);
      return (a == VAL_X) ? VAL_X : (a ^ 2'd1);
   endfunction

   function automatic logic [1:0] t_xor(input logic [1:0] a, input logic [1:0] b);
      if (a == VAL_X || b == VAL_X) return VAL_X;
      return a ^ b;
   endfunction

   function automatic logic is_andlike(input logic [3:0] k);
      return k == KIND_AND || k == KIND_NAND;
   endfunction

   function automatic logic is_orlike(input logic [3:0] k);
      return k == KIND_OR || k == KIND_NOR;
   endfunction

   function automatic logic is_xorlike(input logic [3:0] k);
      return k == KIND_XOR || k == KIND_XNOR;
   endfunction

   function automatic logic is_single(input logic [3:0] k);
      return k == KIND_NOT || k == KIND_BUF || k == KIND_DFF || k == KIND_OUTPUT;
   endfunction

endpackage

// ----- rtl/levelized_event_logic_simulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// levelized_event_logic_simulator
// Event-driven, levelised three-valued gate simulator built around memories.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Items load gate
// records and fanin or fanout list entries, apply a value to a net, run the
// level event lists, or read a net or flip-flop value. Every item gives one
// result on the rsp_ ports, marked by rsp_strobe for a single cycle; the
// receiver cannot hold it off, and the next item may be taken in that cycle.
// An apply also schedules each fanout of the net when its value changed. A
// run visits the levels in order, evaluates each event by reading its
// fanins, schedules the fanouts of each net whose value changed, and then
// moves the deferred level-0 events into level 0; the sequencer issues one
// access per memory port each cycle.
// After reset the block clears net values, scheduled marks, level fill
// counts and flip-flop states in a pass over max(NET_COUNT, LEVEL_COUNT,
// FF_COUNT) entries, one entry per cycle, and holds busy high throughout.
// ----------------------------------------------------------------------------
module levelized_event_logic_simulator #(
   parameter int NET_COUNT         = lels_pkg::NET_COUNT_DEF,
   parameter int MAX_FANIN         = lels_pkg::MAX_FANIN_DEF,
   parameter int MAX_FANOUT        = lels_pkg::MAX_FANOUT_DEF,
   parameter int LEVEL_COUNT       = lels_pkg::LEVEL_COUNT_DEF,
   parameter int LEVEL_QUEUE_DEPTH = lels_pkg::LEVEL_QUEUE_DEPTH_DEF,
   parameter int FF_COUNT          = lels_pkg::FF_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_mode,
   input  logic [9:0] req_net_index,
   input  logic [3:0] req_gate_kind,
   input  logic [5:0] req_level_number,
   input  logic [3:0] req_fanin_count,
   input  logic [3:0] req_fanout_count,
   input  logic [2:0] req_slot,
   input  logic [9:0] req_link_net,
   input  logic [1:0] req_logic_value,
   input  logic [7:0] req_ff_number,
   output logic       rsp_strobe,
   output logic [1:0] rsp_read_value,
   output logic       rsp_run_done,
   output logic       rsp_queue_overflow
);

   localparam int NW   = $clog2(NET_COUNT);
   localparam int FIW  = $clog2(NET_COUNT * MAX_FANIN);
   localparam int FOW  = $clog2(NET_COUNT * MAX_FANOUT);
   localparam int LW   = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
   localparam int EW   = $clog2(LEVEL_COUNT * LEVEL_QUEUE_DEPTH);
   localparam int QW   = $clog2(LEVEL_QUEUE_DEPTH + 1);
   localparam int DW   = $clog2(LEVEL_QUEUE_DEPTH);
   localparam int CIW  = $clog2(MAX_FANIN + 1);
   localparam int COW  = $clog2(MAX_FANOUT + 1);
   localparam int FFW  = (FF_COUNT > 1) ? $clog2(FF_COUNT) : 1;
   localparam int RUN_LIMIT = NET_COUNT + LEVEL_COUNT * LEVEL_QUEUE_DEPTH;
   localparam int PW   = $clog2(RUN_LIMIT + 1);
   localparam int CLR_N0 = (NET_COUNT > LEVEL_COUNT) ? NET_COUNT : LEVEL_COUNT;
   localparam int CLR_N  = (CLR_N0 > FF_COUNT) ? CLR_N0 : FF_COUNT;
   localparam int CW   = $clog2(CLR_N);

   typedef enum logic [22:0] {
      S_CLEAR    = 23'b1 << 0,
      S_IDLE     = 23'b1 << 1,
      S_RD_WAIT  = 23'b1 << 2,
      S_AP_CMP   = 23'b1 << 3,
      S_RESP     = 23'b1 << 4,
      S_SCH_GREC = 23'b1 << 5,
      S_SCH_CNT  = 23'b1 << 6,
      S_SCH_NEXT = 23'b1 << 7,
      S_SCH_S    = 23'b1 << 8,
      S_SCH_CHK  = 23'b1 << 9,
      S_SCH_PUSH = 23'b1 << 10,
      S_RUN_FILL = 23'b1 << 11,
      S_RUN_POP  = 23'b1 << 12,
      S_EV_NET   = 23'b1 << 13,
      S_EV_REC   = 23'b1 << 14,
      S_EV_IN    = 23'b1 << 15,
      S_EV_INV   = 23'b1 << 16,
      S_EV_FOLD  = 23'b1 << 17,
      S_EV_RES   = 23'b1 << 18,
      S_DEF_NEXT = 23'b1 << 19,
      S_DEF_A    = 23'b1 << 20,
      S_DEF_PUSH = 23'b1 << 21,
      S_DEF_CAP  = 23'b1 << 22
   } state_type;

   // Memories.
   logic [3:0]   kind_mem [NET_COUNT];
   logic [LW-1:0] lvl_mem [NET_COUNT];
   logic [CIW-1:0] fic_mem [NET_COUNT];
   logic [COW-1:0] foc_mem [NET_COUNT];
   logic [7:0]   ffn_mem  [NET_COUNT];
   logic [NW-1:0] fi_mem  [NET_COUNT * MAX_FANIN];
   logic [NW-1:0] fo_mem  [NET_COUNT * MAX_FANOUT];
   logic [1:0]   val_mem  [NET_COUNT];
   logic         mark_mem [NET_COUNT];
   logic [NW-1:0] ev_mem  [LEVEL_COUNT * LEVEL_QUEUE_DEPTH];
   logic [QW-1:0] fill_mem [LEVEL_COUNT];
   logic [NW-1:0] def_mem [LEVEL_QUEUE_DEPTH];
   logic [1:0]   ff_mem   [FF_COUNT];

   // Memory ports.
   logic           gr_we;
   logic [NW-1:0]  gr_wa, gr_ra;
   logic [LW-1:0]  gr_lvl_wd;
   logic [CIW-1:0] gr_fic_wd;
   logic [COW-1:0] gr_foc_wd;
   logic [3:0]     gr_kind_q;
   logic [LW-1:0]  gr_lvl_q;
   logic [CIW-1:0] gr_fic_q;
   logic [COW-1:0] gr_foc_q;
   logic [7:0]     gr_ffn_q;
   logic           fi_we;
   logic [FIW-1:0] fi_wa, fi_ra;
   logic [NW-1:0]  fi_q;
   logic           fo_we;
   logic [FOW-1:0] fo_wa, fo_ra;
   logic [NW-1:0]  fo_q, link_wd;
   logic           val_we;
   logic [NW-1:0]  val_wa, val_ra;
   logic [1:0]     val_wd, val_q;
   logic           mark_we, mark_wd, mark_q;
   logic [NW-1:0]  mark_wa, mark_ra;
   logic           ev_we;
   logic [EW-1:0]  ev_wa, ev_ra;
   logic [NW-1:0]  ev_wd, ev_q;
   logic           fill_we;
   logic [LW-1:0]  fill_wa, fill_ra;
   logic [QW-1:0]  fill_wd, fill_q;
   logic           def_we;
   logic [DW-1:0]  def_wa, def_ra;
   logic [NW-1:0]  def_wd, def_q;
   logic           ff_we;
   logic [FFW-1:0] ff_wa, ff_ra;
   logic [1:0]     ff_wd, ff_q;

   // Sequencer registers.
   state_type      state_ff, state_in;
   logic [CW-1:0]  clr_ff, clr_in;
   logic [2:0]     mode_ff, mode_in;
   logic           ok_ff, ok_in;
   logic [NW-1:0]  cur_ff, cur_in;
   logic [1:0]     aval_ff, aval_in;
   logic           in_run_ff, in_run_in;
   logic [COW-1:0] i_ff, i_in, foc_ff, foc_in;
   logic [NW-1:0]  s_ff, s_in;
   logic [LW-1:0]  slvl_ff, slvl_in, rlvl_ff, rlvl_in;
   logic [PW-1:0]  proc_ff, proc_in;
   logic [3:0]     kind_ff, kind_in;
   logic [1:0]     own_ff, own_in;
   logic [CIW-1:0] cnt_ff, cnt_in, j_ff, j_in;
   logic [QW-1:0]  k_ff, k_in, dfill_ff, dfill_in;
   logic [NW-1:0]  a_ff, a_in;
   logic [7:0]     ffn_ff, ffn_in;
   logic [1:0]     rv_ff, rv_in;
   logic           rd_ff, rd_in, drop_ff, drop_in, strobe_ff, strobe_in;

   lels_pkg::fold_ctl_type fold_ctl;
   logic [1:0]     fold_result;

   logic           req_net_ok;
   logic [NW-1:0]  req_net;
   logic [QW-1:0]  fill_dec;

   assign req_net_ok = 32'(req_net_index) < NET_COUNT;
   assign req_net    = NW'(32'(req_net_index));
   assign fill_dec   = fill_q - QW'(1);

   lels_fold u_fold (
      .clock       (clock),
      .ctl         (fold_ctl),
      .fanin_value (val_q),
      .own_value   (own_ff),
      .result      (fold_result)
   );

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      mode_in   = mode_ff;
      ok_in     = ok_ff;
      cur_in    = cur_ff;
      aval_in   = aval_ff;
      in_run_in = in_run_ff;
      i_in      = i_ff;
      foc_in    = foc_ff;
      s_in      = s_ff;
      slvl_in   = slvl_ff;
      rlvl_in   = rlvl_ff;
      proc_in   = proc_ff;
      kind_in   = kind_ff;
      own_in    = own_ff;
      cnt_in    = cnt_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      dfill_in  = dfill_ff;
      a_in      = a_ff;
      ffn_in    = ffn_ff;
      rv_in     = rv_ff;
      rd_in     = rd_ff;
      drop_in   = drop_ff;
      strobe_in = 1'b0;

      gr_we = 1'b0; gr_wa = req_net; gr_ra = '0;
      gr_lvl_wd = (32'(req_level_number) < LEVEL_COUNT) ? LW'(32'(req_level_number))
                                                        : LW'(LEVEL_COUNT - 1);
      gr_fic_wd = (32'(req_fanin_count) < MAX_FANIN) ? CIW'(req_fanin_count)
                                                     : CIW'(MAX_FANIN);
      gr_foc_wd = (32'(req_fanout_count) < MAX_FANOUT) ? COW'(req_fanout_count)
                                                       : COW'(MAX_FANOUT);
      link_wd = NW'(32'(req_link_net));
      fi_we = 1'b0; fi_ra = '0;
      fi_wa = FIW'(32'(req_net) * MAX_FANIN + 32'(req_slot));
      fo_we = 1'b0; fo_ra = '0;
      fo_wa = FOW'(32'(req_net) * MAX_FANOUT + 32'(req_slot));
      val_we = 1'b0; val_wa = cur_ff; val_wd = lels_pkg::VAL_X; val_ra = '0;
      mark_we = 1'b0; mark_wa = s_ff; mark_wd = 1'b0; mark_ra = '0;
      ev_we = 1'b0; ev_wa = '0; ev_wd = s_ff; ev_ra = '0;
      fill_we = 1'b0; fill_wa = slvl_ff; fill_wd = fill_q + QW'(1); fill_ra = '0;
      def_we = 1'b0; def_wa = DW'(dfill_ff); def_wd = s_ff; def_ra = '0;
      ff_we = 1'b0; ff_wa = FFW'(32'(ffn_ff)); ff_wd = val_q; ff_ra = '0;
      fold_ctl.clear = 1'b0;
      fold_ctl.step  = 1'b0;
      fold_ctl.kind  = kind_ff;

      unique case (state_ff)
         S_CLEAR: begin
            if (32'(clr_ff) < NET_COUNT) begin
               val_we = 1'b1; val_wa = NW'(32'(clr_ff));
               mark_we = 1'b1; mark_wa = NW'(32'(clr_ff));
            end
            if (32'(clr_ff) < LEVEL_COUNT) begin
               fill_we = 1'b1; fill_wa = LW'(32'(clr_ff)); fill_wd = '0;
            end
            if (32'(clr_ff) < FF_COUNT) begin
               ff_we = 1'b1; ff_wa = FFW'(32'(clr_ff)); ff_wd = lels_pkg::VAL_X;
            end
            clr_in = clr_ff + CW'(1);
            if (32'(clr_ff) == CLR_N - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               mode_in = req_mode;
               cur_in  = req_net;
               ok_in   = req_net_ok;
               aval_in = (req_logic_value == 2'd3) ? lels_pkg::VAL_X : req_logic_value;
               rv_in   = lels_pkg::VAL_ZERO;
               rd_in   = 1'b0;
               drop_in = 1'b0;
               state_in = S_RESP;
               unique case (req_mode)
                  lels_pkg::MODE_GATE: gr_we = req_net_ok;
                  lels_pkg::MODE_FANIN: fi_we = req_net_ok && 32'(req_slot) < MAX_FANIN
                                                && 32'(req_link_net) < NET_COUNT;
                  lels_pkg::MODE_FANOUT: fo_we = req_net_ok && 32'(req_slot) < MAX_FANOUT
                                                 && 32'(req_link_net) < NET_COUNT;
                  lels_pkg::MODE_APPLY: begin
                     val_ra = req_net;
                     state_in = S_AP_CMP;
                  end
                  lels_pkg::MODE_RUN: begin
                     rlvl_in = '0;
                     proc_in = '0;
                     k_in = '0;
                     state_in = S_RUN_FILL;
                  end
                  lels_pkg::MODE_READ_NET: begin
                     val_ra = req_net;
                     state_in = S_RD_WAIT;
                  end
                  lels_pkg::MODE_READ_FF: begin
                     ff_ra = FFW'(32'(req_ff_number));
                     ok_in = 32'(req_ff_number) < FF_COUNT;
                     state_in = S_RD_WAIT;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_RD_WAIT: begin
            if (!ok_ff) rv_in = lels_pkg::VAL_X;
            else if (mode_ff == lels_pkg::MODE_READ_NET) rv_in = val_q;
            else rv_in = ff_q;
            state_in = S_RESP;
         end
         S_AP_CMP: begin
            if (ok_ff && aval_ff != val_q) begin
               val_we = 1'b1; val_wd = aval_ff;
               in_run_in = 1'b0;
               state_in = S_SCH_GREC;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            strobe_in = 1'b1;
            state_in = S_IDLE;
         end
         S_SCH_GREC: begin
            gr_ra = cur_ff;
            i_in = '0;
            state_in = S_SCH_CNT;
         end
         S_SCH_CNT: begin
            foc_in = gr_foc_q;
            state_in = S_SCH_NEXT;
         end
         S_SCH_NEXT: begin
            if (i_ff < foc_ff) begin
               fo_ra = FOW'(32'(cur_ff) * MAX_FANOUT + 32'(i_ff));
               state_in = S_SCH_S;
            end else begin
               state_in = in_run_ff ? S_RUN_FILL : S_RESP;
            end
         end
         S_SCH_S: begin
            s_in = fo_q;
            mark_ra = fo_q;
            gr_ra = fo_q;
            state_in = S_SCH_CHK;
         end
         S_SCH_CHK: begin
            state_in = S_SCH_NEXT;
            i_in = i_ff + COW'(1);
            if (!mark_q) begin
               if (in_run_ff && gr_lvl_q == '0) begin
                  // Level-0 successors wait in the deferred list until the run ends.
                  if (32'(dfill_ff) >= LEVEL_QUEUE_DEPTH) begin
                     drop_in = 1'b1;
                  end else begin
                     def_we = 1'b1;
                     dfill_in = dfill_ff + QW'(1);
                     mark_we = 1'b1; mark_wd = 1'b1;
                  end
               end else begin
                  fill_ra = gr_lvl_q;
                  slvl_in = gr_lvl_q;
                  i_in = i_ff;
                  state_in = S_SCH_PUSH;
               end
            end
         end
         S_SCH_PUSH: begin
            if (32'(fill_q) >= LEVEL_QUEUE_DEPTH) begin
               drop_in = 1'b1;
            end else begin
               ev_we = 1'b1;
               ev_wa = EW'(32'(slvl_ff) * LEVEL_QUEUE_DEPTH + 32'(fill_q));
               fill_we = 1'b1;
               mark_we = 1'b1; mark_wd = 1'b1;
            end
            i_in = i_ff + COW'(1);
            state_in = S_SCH_NEXT;
         end
         S_RUN_FILL: begin
            fill_ra = rlvl_ff;
            state_in = S_RUN_POP;
         end
         S_RUN_POP: begin
            if (fill_q == '0) begin
               if (32'(rlvl_ff) == LEVEL_COUNT - 1) begin
                  rd_in = 1'b1;
                  state_in = S_DEF_NEXT;
               end else begin
                  rlvl_in = rlvl_ff + LW'(1);
                  state_in = S_RUN_FILL;
               end
            end else if (32'(proc_ff) >= RUN_LIMIT) begin
               rd_in = 1'b0;
               state_in = S_DEF_NEXT;
            end else begin
               fill_we = 1'b1; fill_wa = rlvl_ff; fill_wd = fill_dec;
               ev_ra = EW'(32'(rlvl_ff) * LEVEL_QUEUE_DEPTH + 32'(fill_dec));
               proc_in = proc_ff + PW'(1);
               state_in = S_EV_NET;
            end
         end
         S_EV_NET: begin
            cur_in = ev_q;
            mark_we = 1'b1; mark_wa = ev_q; mark_wd = 1'b0;
            gr_ra = ev_q;
            val_ra = ev_q;
            state_in = S_EV_REC;
         end
         S_EV_REC: begin
            kind_in = gr_kind_q;
            own_in = val_q;
            fold_ctl.clear = 1'b1;
            fold_ctl.kind = gr_kind_q;
            if (lels_pkg::is_andlike(gr_kind_q) || lels_pkg::is_orlike(gr_kind_q)
                || gr_kind_q == lels_pkg::KIND_MYSTERY) begin
               cnt_in = gr_fic_q;
            end else if (lels_pkg::is_xorlike(gr_kind_q)) begin
               cnt_in = (gr_fic_q == '0) ? CIW'(1) : gr_fic_q;
            end else if (lels_pkg::is_single(gr_kind_q)) begin
               cnt_in = CIW'(1);
            end else begin
               cnt_in = '0;
            end
            j_in = '0;
            state_in = S_EV_IN;
         end
         S_EV_IN: begin
            if (j_ff < cnt_ff) begin
               fi_ra = FIW'(32'(cur_ff) * MAX_FANIN + 32'(j_ff));
               state_in = S_EV_INV;
            end else begin
               state_in = S_EV_RES;
            end
         end
         S_EV_INV: begin
            val_ra = fi_q;
            state_in = S_EV_FOLD;
         end
         S_EV_FOLD: begin
            fold_ctl.step = 1'b1;
            j_in = j_ff + CIW'(1);
            state_in = S_EV_IN;
         end
         S_EV_RES: begin
            if (fold_result != own_ff) begin
               val_we = 1'b1; val_wd = fold_result;
               in_run_in = 1'b1;
               state_in = S_SCH_GREC;
            end else begin
               state_in = S_RUN_FILL;
            end
         end
         S_DEF_NEXT: begin
            if (k_ff < dfill_ff) begin
               def_ra = DW'(k_ff);
               state_in = S_DEF_A;
            end else begin
               dfill_in = '0;
               state_in = S_RESP;
            end
         end
         S_DEF_A: begin
            a_in = def_q;
            fill_ra = '0;
            gr_ra = def_q;
            fi_ra = FIW'(32'(def_q) * MAX_FANIN);
            state_in = S_DEF_PUSH;
         end
         S_DEF_PUSH: begin
            if (32'(fill_q) >= LEVEL_QUEUE_DEPTH) begin
               drop_in = 1'b1;
            end else begin
               ev_we = 1'b1; ev_wa = EW'(32'(fill_q)); ev_wd = a_ff;
               fill_we = 1'b1; fill_wa = '0;
            end
            mark_we = 1'b1; mark_wa = a_ff; mark_wd = 1'b0;
            ffn_in = gr_ffn_q;
            val_ra = fi_q;
            state_in = S_DEF_CAP;
         end
         S_DEF_CAP: begin
            ff_we = 32'(ffn_ff) < FF_COUNT;
            k_in = k_ff + QW'(1);
            state_in = S_DEF_NEXT;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         dfill_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         dfill_ff  <= dfill_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      ok_ff     <= ok_in;
      cur_ff    <= cur_in;
      aval_ff   <= aval_in;
      in_run_ff <= in_run_in;
      i_ff      <= i_in;
      foc_ff    <= foc_in;
      s_ff      <= s_in;
      slvl_ff   <= slvl_in;
      rlvl_ff   <= rlvl_in;
      proc_ff   <= proc_in;
      kind_ff   <= kind_in;
      own_ff    <= own_in;
      cnt_ff    <= cnt_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      a_ff      <= a_in;
      ffn_ff    <= ffn_in;
      rv_ff     <= rv_in;
      rd_ff     <= rd_in;
      drop_ff   <= drop_in;
   end

   always_ff @(posedge clock) begin
      if (gr_we) begin
         kind_mem[gr_wa] <= req_gate_kind;
         lvl_mem[gr_wa]  <= gr_lvl_wd;
         fic_mem[gr_wa]  <= gr_fic_wd;
         foc_mem[gr_wa]  <= gr_foc_wd;
         ffn_mem[gr_wa]  <= req_ff_number;
      end
      gr_kind_q <= kind_mem[gr_ra];
      gr_lvl_q  <= lvl_mem[gr_ra];
      gr_fic_q  <= fic_mem[gr_ra];
      gr_foc_q  <= foc_mem[gr_ra];
      gr_ffn_q  <= ffn_mem[gr_ra];
   end

   always_ff @(posedge clock) begin
      if (fi_we) fi_mem[fi_wa] <= link_wd;
      fi_q <= fi_mem[fi_ra];
   end

   always_ff @(posedge clock) begin
      if (fo_we) fo_mem[fo_wa] <= link_wd;
      fo_q <= fo_mem[fo_ra];
   end

   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_wa] <= val_wd;
      val_q <= val_mem[val_ra];
   end

   always_ff @(posedge clock) begin
      if (mark_we) mark_mem[mark_wa] <= mark_wd;
      mark_q <= mark_mem[mark_ra];
   end

   always_ff @(posedge clock) begin
      if (ev_we) ev_mem[ev_wa] <= ev_wd;
      ev_q <= ev_mem[ev_ra];
   end

   always_ff @(posedge clock) begin
      if (fill_we) fill_mem[fill_wa] <= fill_wd;
      fill_q <= fill_mem[fill_ra];
   end

   always_ff @(posedge clock) begin
      if (def_we) def_mem[def_wa] <= def_wd;
      def_q <= def_mem[def_ra];
   end

   always_ff @(posedge clock) begin
      if (ff_we) ff_mem[ff_wa] <= ff_wd;
      ff_q <= ff_mem[ff_ra];
   end

   assign busy               = state_ff != S_IDLE;
   assign rsp_strobe         = strobe_ff;
   assign rsp_read_value     = rv_ff;
   assign rsp_run_done       = rd_ff;
   assign rsp_queue_overflow = drop_ff;

`ifndef SYNTHESIS
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result shown while busy");
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe) else $error("result in cycle after accept");
   a_deferred_bound: assert property (@(posedge clock) disable iff (reset)
      32'(dfill_ff) <= LEVEL_QUEUE_DEPTH) else $error("deferred list overfilled");
   a_run_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_run_done) |-> rsp_read_value == lels_pkg::VAL_ZERO)
      else $error("run item returned a read value");
`endif

endmodule

// ----- rtl/lels_fold.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lels_fold
// Gate evaluation accumulator: folds one fanin value per step and forms the
// gate's new value from the accumulator, the kind and the net's own value.
// ----------------------------------------------------------------------------
module lels_fold (
   input  logic                  clock,
   input  lels_pkg::fold_ctl_type ctl,
   input  logic [1:0]            fanin_value,
   input  logic [1:0]            own_value,
   output logic [1:0]            result
);

   logic [1:0] acc_ff;
   logic [1:0] acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = lels_pkg::is_andlike(ctl.kind) ? lels_pkg::VAL_ONE : lels_pkg::VAL_ZERO;
      end else if (ctl.step) begin
         if (lels_pkg::is_andlike(ctl.kind)) begin
            acc_in = lels_pkg::t_and(acc_ff, fanin_value);
         end else if (lels_pkg::is_xorlike(ctl.kind)) begin
            acc_in = lels_pkg::t_xor(acc_ff, fanin_value);
         end else if (ctl.kind == lels_pkg::KIND_MYSTERY) begin
            acc_in = (fanin_value == lels_pkg::VAL_X) ? lels_pkg::VAL_X : acc_ff;
         end else begin
            // Single-input kinds fold once from zero, which passes the value.
            acc_in = lels_pkg::t_or(acc_ff, fanin_value);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   always_comb begin
      unique case (ctl.kind)
         lels_pkg::KIND_AND, lels_pkg::KIND_OR, lels_pkg::KIND_XOR,
         lels_pkg::KIND_BUF, lels_pkg::KIND_DFF, lels_pkg::KIND_OUTPUT: result = acc_ff;
         lels_pkg::KIND_NAND, lels_pkg::KIND_NOR, lels_pkg::KIND_XNOR,
         lels_pkg::KIND_NOT: result = lels_pkg::t_not(acc_ff);
         lels_pkg::KIND_MYSTERY: result = (acc_ff == lels_pkg::VAL_X) ? lels_pkg::VAL_X
                                                                      : own_value;
         default: result = own_value;
      endcase
   end

endmodule
